### hw/rtl/cpdc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpdc_pkg
// Shared types and constants for the column post decoder with row clipping.
// ----------------------------------------------------------------------------
package cpdc_pkg;

   // Field widths of the beats
   localparam int BYTE_BITS   = 8;
   localparam int ORIGIN_BITS = 16;
   localparam int HEIGHT_BITS = 15;
   localparam int WROW_BITS   = 15;

   // Running row: origin (16b signed) + top (<255) + pixel count (<=255)
   localparam int NROW_BITS = 18;

   // Default width of the latched column height
   localparam int ROW_BITS_DEFAULT = 15;

   // Top byte value that ends a column
   localparam logic [BYTE_BITS-1:0] END_MARK = 8'hff;

   // Post parse phases
   typedef enum logic [2:0] {
      PH_DONE = 3'd0,
      PH_TOP  = 3'd1,
      PH_LEN  = 3'd2,
      PH_PAD1 = 3'd3,
      PH_PIX  = 3'd4,
      PH_PAD2 = 3'd5
   } phase_type;

   // One result beat
   typedef struct packed {
      logic                 write_enable;
      logic [WROW_BITS-1:0] write_row;
      logic [BYTE_BITS-1:0] write_value;
      logic                 column_end;
   } rslt_type;

endpackage : cpdc_pkg
`default_nettype wire

### hw/rtl/column_post_decoder_clip_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// column_post_decoder_clip_unit
// Decodes a run-length picture column one stream byte per beat and issues
// one clipped pixel write (or a null beat) per input byte.
// ----------------------------------------------------------------------------
// Usage: feed the encoded column one byte per req beat, with req_column_start
// high on the first byte (the top byte of the first post); origin and height
// are captured on that beat. Every input beat yields exactly one rsp beat.
// The block takes one byte per clock while rsp_ready keeps up: the parse
// state and the clip compare (a sign check and one 18-bit compare) sit
// between the input handshake and the result register, and a two-entry
// output stage (result register plus skid register) keeps req_ready high
// for one more beat while a result waits on rsp_ready; then req_ready drops.
// rsp_write_enable is high only for pixel bytes whose row lies in
// 0..height-1; rsp_column_end flags the 0xff end marker. Bytes after the end
// marker give all-zero beats until the next column start.
// ----------------------------------------------------------------------------
module column_post_decoder_clip_unit #(
   parameter int ROW_BITS = cpdc_pkg::ROW_BITS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // input channel
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [cpdc_pkg::BYTE_BITS-1:0]     req_stream_byte,
   input  wire logic                               req_column_start,
   input  wire logic signed [cpdc_pkg::ORIGIN_BITS-1:0] req_origin_row,
   input  wire logic [cpdc_pkg::HEIGHT_BITS-1:0]   req_column_height,
   // result channel
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_write_enable,
   output logic [cpdc_pkg::WROW_BITS-1:0]          rsp_write_row,
   output logic [cpdc_pkg::BYTE_BITS-1:0]          rsp_write_value,
   output logic                                    rsp_column_end
);

   // Height register width: height field masked to ROW_BITS bits, at most HEIGHT_BITS
   localparam int HGT_BITS = (ROW_BITS < cpdc_pkg::HEIGHT_BITS) ?
                             ROW_BITS : cpdc_pkg::HEIGHT_BITS;
   localparam int NRB      = cpdc_pkg::NROW_BITS;
   localparam int OB       = cpdc_pkg::ORIGIN_BITS;
   localparam int BB       = cpdc_pkg::BYTE_BITS;

   // ---------------------------------------------------------------- state
   cpdc_pkg::phase_type        phase_ff, phase_in;
   logic [NRB-1:0]             next_row_ff, next_row_in;   // signed value
   logic [BB-1:0]              bytes_left_ff, bytes_left_in;
   logic [OB-1:0]              origin_ff, origin_in;
   logic [HGT_BITS-1:0]        height_ff, height_in;

   // output stage: head register and skid register
   logic                       rsp_valid_ff, rsp_valid_in;
   cpdc_pkg::rslt_type         rsp_data_ff, rsp_data_in;
   logic                       skid_valid_ff, skid_valid_in;
   cpdc_pkg::rslt_type         skid_data_ff, skid_data_in;

   logic                       push;
   logic                       pop;
   cpdc_pkg::rslt_type         rslt;

   // effective values for this beat (a start overrides the held column)
   cpdc_pkg::phase_type        cur_phase;
   logic [OB-1:0]              cur_origin;
   logic [HGT_BITS-1:0]        cur_height;
   logic                       row_inside;
   logic [BB-1:0]              bytes_dec;

   assign req_ready = !skid_valid_ff;
   assign push      = req_valid && req_ready;
   assign pop       = rsp_valid_ff && rsp_ready;

   assign cur_phase  = req_column_start ? cpdc_pkg::PH_TOP : phase_ff;
   assign cur_origin = req_column_start ? req_origin_row : origin_ff;
   assign cur_height = req_column_start ? req_column_height[HGT_BITS-1:0]
                                        : height_ff;

   // row clip: 0 <= next_row < height
   assign row_inside = !next_row_ff[NRB-1] && (next_row_ff < NRB'(cur_height));
   assign bytes_dec  = bytes_left_ff - BB'(1);

   // ------------------------------------------------------- next-state logic
   always_comb begin
      phase_in      = cur_phase;
      next_row_in   = next_row_ff;
      bytes_left_in = bytes_left_ff;
      origin_in     = cur_origin;
      height_in     = cur_height;
      case (cur_phase)
         cpdc_pkg::PH_TOP: begin
            if (req_stream_byte == cpdc_pkg::END_MARK) begin
               phase_in = cpdc_pkg::PH_DONE;
            end else begin
               next_row_in = {{(NRB-OB){cur_origin[OB-1]}}, cur_origin}
                           + NRB'(req_stream_byte);
               phase_in    = cpdc_pkg::PH_LEN;
            end
         end
         cpdc_pkg::PH_LEN: begin
            bytes_left_in = req_stream_byte;
            phase_in      = cpdc_pkg::PH_PAD1;
         end
         cpdc_pkg::PH_PAD1: begin
            phase_in = (bytes_left_ff != '0) ? cpdc_pkg::PH_PIX
                                             : cpdc_pkg::PH_PAD2;
         end
         cpdc_pkg::PH_PIX: begin
            next_row_in   = next_row_ff + NRB'(1);
            bytes_left_in = bytes_dec;
            if (bytes_dec == '0) begin
               phase_in = cpdc_pkg::PH_PAD2;
            end
         end
         cpdc_pkg::PH_PAD2: begin
            phase_in = cpdc_pkg::PH_TOP;
         end
         default: begin
            phase_in = cpdc_pkg::PH_DONE;
         end
      endcase
   end

   // ------------------------------------------------------------ result logic
   always_comb begin
      rslt = '0;
      case (cur_phase)
         cpdc_pkg::PH_TOP: begin
            rslt.column_end = (req_stream_byte == cpdc_pkg::END_MARK);
         end
         cpdc_pkg::PH_PIX: begin
            if (row_inside) begin
               rslt.write_enable = 1'b1;
               rslt.write_row    = next_row_ff[cpdc_pkg::WROW_BITS-1:0];
               rslt.write_value  = req_stream_byte;
            end
         end
         default: begin
            rslt = '0;
         end
      endcase
   end

   // ------------------------------------------------------ output stage ctl
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         // input is stalled; drain skid into head on pop
         if (pop) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!rsp_valid_ff || pop) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = rslt;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = rslt;
         end
      end else if (pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   // --------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= cpdc_pkg::PH_DONE;
         next_row_ff   <= '0;
         bytes_left_ff <= '0;
         origin_ff     <= '0;
         height_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (push) begin
            phase_ff      <= phase_in;
            next_row_ff   <= next_row_in;
            bytes_left_ff <= bytes_left_in;
            origin_ff     <= origin_in;
            height_ff     <= height_in;
         end
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_write_enable = rsp_data_ff.write_enable;
   assign rsp_write_row    = rsp_data_ff.write_row;
   assign rsp_write_value  = rsp_data_ff.write_value;
   assign rsp_column_end   = rsp_data_ff.column_end;

   // -------------------------------------------------------------- assertions
   a_skid_behind_head: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry held with empty result register");

   a_pix_has_bytes: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == cpdc_pkg::PH_PIX) |-> (bytes_left_ff != '0))
      else $error("pixel phase with no bytes left");

   a_end_stops_column: assert property (@(posedge clock) disable iff (reset)
      (push && req_column_start && (req_stream_byte == cpdc_pkg::END_MARK))
      |=> (phase_ff == cpdc_pkg::PH_DONE))
      else $error("end marker did not close the column");

   a_write_not_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.write_enable && rsp_data_ff.column_end))
      else $error("pixel write flagged as column end");

   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      (push && !rsp_valid_ff) |=> (rsp_valid_ff && !skid_valid_ff))
      else $error("beat into empty output stage lost or misplaced");

endmodule : column_post_decoder_clip_unit
`default_nettype wire
